### design/cpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and constants of the counter priority task scheduler
// Command and result structs, command, status and task state codes.
// ----------------------------------------------------------------------------
package cpts_pkg;

   localparam logic [2:0] FUNC_ADD      = 3'd0;
   localparam logic [2:0] FUNC_SCHEDULE = 3'd1;
   localparam logic [2:0] FUNC_YIELD    = 3'd2;
   localparam logic [2:0] FUNC_BLOCK    = 3'd3;
   localparam logic [2:0] FUNC_WAKE     = 3'd4;

   localparam logic [2:0] STAT_DONE     = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_WAKEMISS = 3'd2;
   localparam logic [2:0] STAT_NORUN    = 3'd3;
   localparam logic [2:0] STAT_NOCUR    = 3'd4;

   localparam logic [2:0] TS_RUNNING  = 3'd1;
   localparam logic [2:0] TS_RUNNABLE = 3'd2;
   localparam logic [2:0] TS_BLOCKED  = 3'd3;
   localparam logic [2:0] TS_IDLE     = 3'd5;

   localparam logic [10:0] ID_START = 11'd1000;

   typedef struct packed {
      logic [2:0]        func;
      logic signed [7:0] priority_req;
      logic [2:0]        initial_state;
      logic [2:0]        wait_reason;
      logic [10:0]       task_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  cur_slot;
      logic        cur_valid;
      logic [10:0] result_id;
      logic        first_start;
      logic        switched;
      logic [6:0]  runnable_count;
      logic [6:0]  blocked_count;
      logic [6:0]  task_total;
   } rsp_type;

endpackage

### design/counter_priority_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler: counter based task table and scheduler
// A sequencer walks the slot table one slot a cycle through one shared
// compare and update unit for picks, recalculation, wake search and counts.
// ----------------------------------------------------------------------------
//  channel | ports                     | transfer
//  command | start, busy, req_data     | start high while busy low
//  result  | rsp_valid, rsp_data       | one cycle strobe, cannot stall
//
//  Each scan visits the slots filled after the command, one slot a cycle.
//  An add, unknown command or early status runs only the tally scan; a wake
//  search or a pick scan goes before it, an idle task search follows the pick
//  scan, and a schedule that recalculates once runs pick, recalc and pick.
//  busy is high from the accepting edge until the result strobe.
//  Reset clears control state only; slot storage is undefined until added.
//  The receiver cannot stall; every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler #(
   parameter int MAX_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cpts_pkg::req_type req_data,
   output logic              rsp_valid,
   output cpts_pkg::rsp_type rsp_data
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PRE    = 4'd1;
   localparam logic [3:0] S_PICK   = 4'd2;
   localparam logic [3:0] S_RECALC = 4'd3;
   localparam logic [3:0] S_IDLEFD = 4'd4;
   localparam logic [3:0] S_CHOSE  = 4'd5;
   localparam logic [3:0] S_WAKE   = 4'd6;
   localparam logic [3:0] S_COUNT  = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_TALLY  = 4'd9;

   // slot table
   logic [10:0] slot_id_ff      [MAX_SLOTS];
   logic [2:0]  slot_state_ff   [MAX_SLOTS];
   logic [6:0]  slot_priority_ff[MAX_SLOTS];
   logic [7:0]  slot_counter_ff [MAX_SLOTS];
   logic [2:0]  slot_wait_ff    [MAX_SLOTS];
   logic        slot_started_ff [MAX_SLOTS];

   logic [3:0]        state_ff;
   logic [CW-1:0]     filled_ff;
   logic [5:0]        run_slot_ff;
   logic              run_valid_ff;
   logic [10:0]       last_id_ff;
   cpts_pkg::req_type req_ff;
   logic [CW-1:0]     idx_ff;
   logic              pass_ff;
   logic              any_ff;
   logic              best_hit_ff;
   logic [SW-1:0]     best_ff;
   logic [7:0]        best_cnt_ff;
   logic              had_old_ff;
   logic [2:0]        status_ff;
   logic              have_rid_ff;
   logic [10:0]       rid_ff;
   logic              first_ff;
   logic              sw_ff;
   logic [6:0]        nrun_ff;
   logic [6:0]        nblk_ff;

   logic [SW-1:0] idx_s;
   logic [SW-1:0] cur_s;
   logic          cur_ok;
   logic          last_idx;
   logic [2:0]    st_i;
   logic          act_i;
   logic [8:0]    recalc_sum;

   assign idx_s    = idx_ff[SW-1:0];
   assign cur_s    = run_slot_ff[SW-1:0];
   assign cur_ok   = run_valid_ff && ({1'b0, run_slot_ff} < 7'(filled_ff))
                     && (32'(run_slot_ff) < MAX_SLOTS);
   assign last_idx = (idx_ff + CW'(1)) >= filled_ff;
   assign st_i     = slot_state_ff[idx_s];
   assign act_i    = (st_i == cpts_pkg::TS_RUNNING) || (st_i == cpts_pkg::TS_RUNNABLE);
   assign recalc_sum = 9'(slot_counter_ff[idx_s] >> 1) + 9'(slot_priority_ff[idx_s]);
   assign busy     = (state_ff != S_IDLE);

   // sequencer and table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         last_id_ff   <= cpts_pkg::ID_START;
         rsp_valid    <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff      <= req_data;
                  status_ff   <= cpts_pkg::STAT_DONE;
                  have_rid_ff <= 1'b0;
                  first_ff    <= 1'b0;
                  sw_ff       <= 1'b0;
                  state_ff    <= S_PRE;
               end
            end
            S_PRE: begin
               idx_ff      <= '0;
               pass_ff     <= 1'b0;
               best_hit_ff <= 1'b0;
               best_cnt_ff <= '0;
               had_old_ff  <= cur_ok;
               case (req_ff.func) inside
                  cpts_pkg::FUNC_ADD: begin
                     if (32'(filled_ff) >= MAX_SLOTS) begin
                        status_ff <= cpts_pkg::STAT_FULL;
                     end else begin
                        slot_id_ff[filled_ff[SW-1:0]]    <= last_id_ff + 11'd1;
                        slot_state_ff[filled_ff[SW-1:0]] <= req_ff.initial_state;
                        slot_priority_ff[filled_ff[SW-1:0]] <= (req_ff.priority_req > 0)
                           ? req_ff.priority_req[6:0] : 7'd1;
                        slot_counter_ff[filled_ff[SW-1:0]] <= (req_ff.priority_req > 0)
                           ? {1'b0, req_ff.priority_req[6:0]} : 8'd1;
                        slot_wait_ff[filled_ff[SW-1:0]]    <= '0;
                        slot_started_ff[filled_ff[SW-1:0]] <= 1'b0;
                        filled_ff   <= filled_ff + CW'(1);
                        last_id_ff  <= last_id_ff + 11'd1;
                        rid_ff      <= last_id_ff + 11'd1;
                        have_rid_ff <= 1'b1;
                     end
                     state_ff <= S_COUNT;
                  end
                  cpts_pkg::FUNC_SCHEDULE, cpts_pkg::FUNC_YIELD, cpts_pkg::FUNC_BLOCK: begin
                     if (req_ff.func == cpts_pkg::FUNC_BLOCK
                         && (!cur_ok || slot_state_ff[cur_s] == cpts_pkg::TS_IDLE)) begin
                        status_ff <= cpts_pkg::STAT_NOCUR;
                        state_ff  <= S_COUNT;
                     end else if (filled_ff == '0) begin
                        status_ff <= cpts_pkg::STAT_NORUN;
                        state_ff  <= S_COUNT;
                     end else begin
                        // demote, zero or block the current task before the pick
                        if (cur_ok && slot_state_ff[cur_s] != cpts_pkg::TS_IDLE) begin
                           if (req_ff.func == cpts_pkg::FUNC_BLOCK) begin
                              slot_state_ff[cur_s]   <= cpts_pkg::TS_BLOCKED;
                              slot_wait_ff[cur_s]    <= req_ff.wait_reason;
                              slot_counter_ff[cur_s] <= '0;
                           end else begin
                              if (req_ff.func == cpts_pkg::FUNC_YIELD)
                                 slot_counter_ff[cur_s] <= '0;
                              if (slot_state_ff[cur_s] == cpts_pkg::TS_RUNNING)
                                 slot_state_ff[cur_s] <= cpts_pkg::TS_RUNNABLE;
                           end
                        end
                        any_ff   <= 1'b0;
                        state_ff <= S_PICK;
                     end
                  end
                  cpts_pkg::FUNC_WAKE: begin
                     if (filled_ff == '0) begin
                        status_ff <= cpts_pkg::STAT_WAKEMISS;
                        state_ff  <= S_COUNT;
                     end else begin
                        state_ff <= S_WAKE;
                     end
                  end
                  default: state_ff <= S_COUNT;
               endcase
            end
            S_PICK: begin
               // keep the largest positive counter, lowest slot on a tie
               if (act_i && slot_counter_ff[idx_s] > best_cnt_ff) begin
                  best_hit_ff <= 1'b1;
                  best_ff     <= idx_s;
                  best_cnt_ff <= slot_counter_ff[idx_s];
               end
               if (act_i) any_ff <= 1'b1;
               idx_ff <= last_idx ? '0 : idx_ff + CW'(1);
               if (last_idx) begin
                  if (best_hit_ff || (act_i && slot_counter_ff[idx_s] > best_cnt_ff))
                     state_ff <= S_CHOSE;
                  else if ((any_ff || act_i) && !pass_ff)
                     state_ff <= S_RECALC;
                  else if (any_ff || act_i)
                     state_ff <= S_IDLEFD;
                  else
                     state_ff <= S_IDLEFD;
               end
            end
            S_RECALC: begin
               // age every active counter: half plus priority, saturated
               if (act_i)
                  slot_counter_ff[idx_s] <= recalc_sum[8] ? 8'hFF : recalc_sum[7:0];
               idx_ff <= last_idx ? '0 : idx_ff + CW'(1);
               if (last_idx) begin
                  pass_ff  <= 1'b1;
                  any_ff   <= 1'b0;
                  state_ff <= S_PICK;
               end
            end
            S_IDLEFD: begin
               // first idle task
               if (st_i == cpts_pkg::TS_IDLE) begin
                  best_ff  <= idx_s;
                  state_ff <= S_CHOSE;
               end else if (last_idx) begin
                  status_ff <= cpts_pkg::STAT_NORUN;
                  state_ff  <= S_COUNT;
               end
               idx_ff <= idx_ff + CW'(1);
            end
            S_CHOSE: begin
               run_slot_ff  <= 6'(best_ff);
               run_valid_ff <= 1'b1;
               if (slot_state_ff[best_ff] != cpts_pkg::TS_IDLE) begin
                  slot_state_ff[best_ff] <= cpts_pkg::TS_RUNNING;
                  if (slot_counter_ff[best_ff] != '0)
                     slot_counter_ff[best_ff] <= slot_counter_ff[best_ff] - 8'd1;
               end
               if (!(had_old_ff && cur_s == best_ff)) begin
                  sw_ff <= 1'b1;
                  if (!slot_started_ff[best_ff]) begin
                     slot_started_ff[best_ff] <= 1'b1;
                     first_ff <= 1'b1;
                  end
               end
               state_ff <= S_COUNT;
            end
            S_WAKE: begin
               if (slot_id_ff[idx_s] == req_ff.task_id) begin
                  if (st_i == cpts_pkg::TS_BLOCKED) begin
                     slot_state_ff[idx_s] <= cpts_pkg::TS_RUNNABLE;
                     slot_wait_ff[idx_s]  <= '0;
                     if (slot_counter_ff[idx_s] == '0)
                        slot_counter_ff[idx_s] <= {1'b0, slot_priority_ff[idx_s]};
                     rid_ff      <= req_ff.task_id;
                     have_rid_ff <= 1'b1;
                  end else begin
                     status_ff <= cpts_pkg::STAT_WAKEMISS;
                  end
                  state_ff <= S_COUNT;
               end else if (last_idx) begin
                  status_ff <= cpts_pkg::STAT_WAKEMISS;
                  state_ff  <= S_COUNT;
               end
               idx_ff <= idx_ff + CW'(1);
            end
            S_COUNT: begin
               idx_ff   <= '0;
               nrun_ff  <= '0;
               nblk_ff  <= '0;
               state_ff <= (filled_ff == '0) ? S_OUT : S_TALLY;
            end
            S_TALLY: begin
               // tally states one slot a cycle
               if (act_i) nrun_ff <= nrun_ff + 7'd1;
               else if (st_i == cpts_pkg::TS_BLOCKED) nblk_ff <= nblk_ff + 7'd1;
               idx_ff <= idx_ff + CW'(1);
               if (last_idx) state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_data.status         <= status_ff;
               rsp_data.cur_slot       <= run_slot_ff;
               rsp_data.cur_valid      <= run_valid_ff;
               rsp_data.result_id      <= have_rid_ff ? rid_ff
                                          : (cur_ok ? slot_id_ff[cur_s] : 11'd0);
               rsp_data.first_start    <= first_ff;
               rsp_data.switched       <= sw_ff;
               rsp_data.runnable_count <= nrun_ff;
               rsp_data.blocked_count  <= nblk_ff;
               rsp_data.task_total     <= 7'(filled_ff);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= MAX_SLOTS) else $error("fill count overflow");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
`endif

endmodule

### dv/counter_priority_task_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_tb: self-checking bench for the scheduler
// Commands are queued by an initial block and sent by a clocked driver with
// random gaps. A shadow task table predicts every result, and a clocked
// monitor compares each result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_tb;

   localparam int SLOTS = 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   cpts_pkg::req_type req_data = '0;
   logic              rsp_valid;
   cpts_pkg::rsp_type rsp_data;

   counter_priority_task_scheduler #(.MAX_SLOTS(SLOTS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // shadow task table
   logic [10:0] tbl_id [SLOTS];
   logic [2:0]  tbl_state [SLOTS];
   logic [6:0]  tbl_prio [SLOTS];
   logic [7:0]  tbl_count [SLOTS];
   logic        tbl_started [SLOTS];
   int          tbl_filled;
   int          run_slot;
   logic        run_valid;
   logic [10:0] id_seq;

   cpts_pkg::req_type cmd_queue[$];
   cpts_pkg::rsp_type expected_rsp[$];
   int      mismatch_count = 0;
   int      sent_count = 0;
   bit      no_gaps = 1'b0;
   bit      drain_hold = 1'b0;
   int      gap_left = 0;
   int      spin;

   function automatic bit is_active(logic [2:0] s);
      return s == cpts_pkg::TS_RUNNING || s == cpts_pkg::TS_RUNNABLE;
   endfunction

   function automatic bit cur_live();
      return run_valid && run_slot < tbl_filled;
   endfunction

   // pick by largest counter, recalc up to twice, fall back to first idle task
   function automatic int pick_next();
      int best;
      logic [7:0] best_cnt;
      bit any;
      int c;
      for (int pass = 0; pass < 2; pass++) begin
         best = -1;
         best_cnt = '0;
         any = 1'b0;
         for (int i = 0; i < tbl_filled; i++)
            if (is_active(tbl_state[i]) && tbl_count[i] > best_cnt) begin
               best = i;
               best_cnt = tbl_count[i];
            end
         if (best >= 0) return best;
         for (int i = 0; i < tbl_filled; i++)
            if (is_active(tbl_state[i])) begin
               c = int'(tbl_count[i] >> 1) + int'(tbl_prio[i]);
               tbl_count[i] = (c > 255) ? 8'd255 : 8'(c);
               any = 1'b1;
            end
         if (!any) break;
      end
      for (int i = 0; i < tbl_filled; i++)
         if (tbl_state[i] == cpts_pkg::TS_IDLE) return i;
      return -1;
   endfunction

   function automatic logic [2:0] run_schedule(ref logic first, ref logic sw);
      bit had_old;
      int old_slot;
      int nx;
      if (tbl_filled == 0) return cpts_pkg::STAT_NORUN;
      had_old = cur_live();
      old_slot = run_slot;
      if (had_old && tbl_state[old_slot] == cpts_pkg::TS_RUNNING)
         tbl_state[old_slot] = cpts_pkg::TS_RUNNABLE;
      nx = pick_next();
      if (nx < 0) return cpts_pkg::STAT_NORUN;
      run_slot = nx;
      run_valid = 1'b1;
      if (tbl_state[nx] != cpts_pkg::TS_IDLE) begin
         tbl_state[nx] = cpts_pkg::TS_RUNNING;
         if (tbl_count[nx] > 0) tbl_count[nx]--;
      end
      if (had_old && old_slot == nx) return cpts_pkg::STAT_DONE;
      sw = 1'b1;
      if (!tbl_started[nx]) begin
         tbl_started[nx] = 1'b1;
         first = 1'b1;
      end
      return cpts_pkg::STAT_DONE;
   endfunction

   function automatic cpts_pkg::rsp_type predict_command(cpts_pkg::req_type cmd);
      cpts_pkg::rsp_type r;
      logic first, sw, have_id;
      int hit;
      int nrun, nblk;
      r = '0;
      first = 1'b0;
      sw = 1'b0;
      have_id = 1'b0;
      nrun = 0;
      nblk = 0;
      case (cmd.func)
         cpts_pkg::FUNC_ADD: begin
            if (tbl_filled >= SLOTS) r.status = cpts_pkg::STAT_FULL;
            else begin
               id_seq = id_seq + 11'd1;
               tbl_id[tbl_filled] = id_seq;
               tbl_state[tbl_filled] = cmd.initial_state;
               tbl_prio[tbl_filled] = (cmd.priority_req >= 1) ? 7'(cmd.priority_req) : 7'd1;
               tbl_count[tbl_filled] = {1'b0, tbl_prio[tbl_filled]};
               tbl_started[tbl_filled] = 1'b0;
               tbl_filled++;
               r.result_id = id_seq;
               have_id = 1'b1;
            end
         end
         cpts_pkg::FUNC_SCHEDULE: r.status = run_schedule(first, sw);
         cpts_pkg::FUNC_YIELD: begin
            if (cur_live() && tbl_state[run_slot] != cpts_pkg::TS_IDLE)
               tbl_count[run_slot] = '0;
            r.status = run_schedule(first, sw);
         end
         cpts_pkg::FUNC_BLOCK: begin
            if (!cur_live() || tbl_state[run_slot] == cpts_pkg::TS_IDLE)
               r.status = cpts_pkg::STAT_NOCUR;
            else begin
               tbl_state[run_slot] = cpts_pkg::TS_BLOCKED;
               tbl_count[run_slot] = '0;
               r.status = run_schedule(first, sw);
            end
         end
         cpts_pkg::FUNC_WAKE: begin
            hit = -1;
            for (int i = 0; i < tbl_filled; i++)
               if (hit < 0 && tbl_id[i] == cmd.task_id) hit = i;
            if (hit < 0 || tbl_state[hit] != cpts_pkg::TS_BLOCKED)
               r.status = cpts_pkg::STAT_WAKEMISS;
            else begin
               tbl_state[hit] = cpts_pkg::TS_RUNNABLE;
               if (tbl_count[hit] == 0) tbl_count[hit] = {1'b0, tbl_prio[hit]};
               r.result_id = cmd.task_id;
               have_id = 1'b1;
            end
         end
         default: r.status = cpts_pkg::STAT_DONE;
      endcase
      if (!have_id) r.result_id = cur_live() ? tbl_id[run_slot] : 11'd0;
      for (int i = 0; i < tbl_filled; i++)
         if (is_active(tbl_state[i])) nrun++;
         else if (tbl_state[i] == cpts_pkg::TS_BLOCKED) nblk++;
      r.cur_slot = 6'(run_slot);
      r.cur_valid = run_valid;
      r.first_start = first;
      r.switched = sw;
      r.runnable_count = 7'(nrun);
      r.blocked_count = 7'(nblk);
      r.task_total = 7'(tbl_filled);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // drive commands; predict each at its transfer edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_rsp.push_back(predict_command(req_data));
         sent_count++;
         start <= 1'b0;
         if (!no_gaps && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (cmd_queue.size() > 0 && !drain_hold) begin
            req_data <= cmd_queue.pop_front();
            start <= 1'b1;
         end
      end
   end

   // check each result strobe against the oldest prediction
   always @(posedge clock) begin
      cpts_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) report_mismatch("unexpected result", 0, 0);
         else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.cur_slot !== want.cur_slot)
               report_mismatch("cur_slot", rsp_data.cur_slot, want.cur_slot);
            if (rsp_data.cur_valid !== want.cur_valid)
               report_mismatch("cur_valid", rsp_data.cur_valid, want.cur_valid);
            if (rsp_data.result_id !== want.result_id)
               report_mismatch("result_id", rsp_data.result_id, want.result_id);
            if (rsp_data.first_start !== want.first_start)
               report_mismatch("first_start", rsp_data.first_start, want.first_start);
            if (rsp_data.switched !== want.switched)
               report_mismatch("switched", rsp_data.switched, want.switched);
            if (rsp_data.runnable_count !== want.runnable_count)
               report_mismatch("runnable_count", rsp_data.runnable_count,
                               want.runnable_count);
            if (rsp_data.blocked_count !== want.blocked_count)
               report_mismatch("blocked_count", rsp_data.blocked_count, want.blocked_count);
            if (rsp_data.task_total !== want.task_total)
               report_mismatch("task_total", rsp_data.task_total, want.task_total);
         end
      end
   end

   function automatic cpts_pkg::req_type make_cmd(logic [2:0] f, logic [7:0] p,
                                                  logic [2:0] st, logic [2:0] w,
                                                  logic [10:0] id);
      cpts_pkg::req_type c;
      c.func = f;
      c.priority_req = p;
      c.initial_state = st;
      c.wait_reason = w;
      c.task_id = id;
      return c;
   endfunction

   function automatic cpts_pkg::req_type random_cmd(logic [2:0] f);
      return make_cmd(f, 8'($urandom), 3'($urandom), 3'($urandom), 11'($urandom));
   endfunction

   // one random session: a random mix of adds, schedules, yields, blocks and wakes
   task automatic queue_session(int len, logic [10:0] base_id);
      int r;
      cpts_pkg::req_type c;
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 18) begin
            c = random_cmd(cpts_pkg::FUNC_ADD);
            // mostly runnable, some blocked or idle, a few odd states
            case ($urandom_range(0, 9))
               0: c.initial_state = cpts_pkg::TS_IDLE;
               1: c.initial_state = cpts_pkg::TS_BLOCKED;
               2: c.initial_state = 3'($urandom);
               default: c.initial_state = cpts_pkg::TS_RUNNABLE;
            endcase
         end else if (r < 45) c = random_cmd(cpts_pkg::FUNC_SCHEDULE);
         else if (r < 58) c = random_cmd(cpts_pkg::FUNC_YIELD);
         else if (r < 72) c = random_cmd(cpts_pkg::FUNC_BLOCK);
         else if (r < 95) begin
            c = random_cmd(cpts_pkg::FUNC_WAKE);
            if ($urandom_range(0, 4) != 0)
               c.task_id = base_id + 11'($urandom_range(1, SLOTS + 1));
         end else c = random_cmd(3'($urandom_range(5, 7)));
         cmd_queue.push_back(c);
      end
   endtask

   // sample at the falling edge so every rising edge update is settled
   task automatic wait_drained();
      while (cmd_queue.size() > 0 || start || expected_rsp.size() > 0) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      id_seq = cpts_pkg::ID_START;
      tbl_filled = 0;
      run_slot = 0;
      run_valid = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_id[i] = '0;
         tbl_state[i] = '0;
         tbl_prio[i] = '0;
         tbl_count[i] = '0;
         tbl_started[i] = '0;
      end

      // empty table, no current task, then extreme adds and every command
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_SCHEDULE, '0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_YIELD, '0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_BLOCK, '0, '0, 3'd7, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_WAKE, '0, '0, '0, 11'd2047));
      cmd_queue.push_back(make_cmd(3'd7, 8'hff, 3'd7, 3'd7, 11'h7ff));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h80, cpts_pkg::TS_BLOCKED, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_SCHEDULE, '0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h7f, cpts_pkg::TS_RUNNABLE, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h00, cpts_pkg::TS_IDLE, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h01, 3'd7, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h02, cpts_pkg::TS_RUNNING, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_SCHEDULE, '0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_YIELD, '0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_BLOCK, '0, '0, 3'd6, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_BLOCK, '0, '0, 3'd3, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_BLOCK, '0, '0, 3'd1, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_WAKE, '0, '0, '0, 11'd1001));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_WAKE, '0, '0, '0, 11'd1003));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_WAKE, '0, '0, '0, 11'd1999));
      for (int i = 0; i < 13; i++)
         cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'(i * 9 + 1),
                                      cpts_pkg::TS_RUNNABLE, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_ADD, 8'h55, cpts_pkg::TS_RUNNABLE, '0, '0));
      cmd_queue.push_back(make_cmd(cpts_pkg::FUNC_SCHEDULE, '0, '0, '0, '0));

      // random work on the full table, then pause until drained
      queue_session(120, 11'd1000);
      drain_hold = 1'b0;
      wait_drained();

      // the table cannot be emptied without reset: keep working it,
      // with wake ids steered at the existing range
      queue_session(150, 11'd1000);
      wait_drained();
      no_gaps = 1'b1;
      gap_left = 0;
      queue_session(150, 11'd1000);
      wait_drained();

      spin = 0;
      while (spin < 200 && !rsp_valid) begin
         @(posedge clock);
         spin++;
      end
      repeat (2) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
